### design/atlas_shelf_allocator_defines.svh
// Assertion helpers used by the checker file.
`ifndef ATLAS_SHELF_ALLOCATOR_DEFINES_SVH
`define ATLAS_SHELF_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define ASA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("atlas shelf allocator: check failed");

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define ASA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("atlas shelf allocator: check failed");

`endif

### design/asa_pkg.sv
package asa_pkg;

  localparam int MAX_SHELVES        = 64;
  localparam int INITIAL_ATLAS_SIZE = 128;
  localparam int DIM_W              = 15;
  localparam int H10_W              = DIM_W + 4;
  localparam int SHELF_IDX_W        = $clog2(MAX_SHELVES);
  localparam int SHELF_CNT_W        = $clog2(MAX_SHELVES + 1);
  localparam int FIRST_FREE_ROW     = 3;
  localparam int MAX_ATLAS_RESET    = 4096;
  localparam int FAIL_SIZE          = 2;
  // floor(h / 10) == (h * RECIP_10) >> RECIP_SHIFT for every 15-bit h
  localparam int RECIP_10           = 52429;
  localparam int RECIP_W            = 16;
  localparam int RECIP_SHIFT        = 19;

  // Request travelling down the shelf chain
  typedef struct packed {
    logic               vld;
    logic               found;
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [H10_W-1:0]   h10;
    logic [DIM_W-1:0]   left;
    logic [DIM_W-1:0]   top;
  } token_t;

  // Opening of a new shelf
  typedef struct packed {
    logic                   en;
    logic [SHELF_IDX_W-1:0] idx;
    logic [DIM_W-1:0]       top;
    logic [DIM_W-1:0]       height;
    logic [DIM_W-1:0]       used;
  } shelf_wr_t;

endpackage

### design/asa_cell.sv
module asa_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [asa_pkg::SHELF_IDX_W-1:0] cell_idx,
  input  logic                           active,
  input  logic [asa_pkg::DIM_W-1:0]      atlas_width,
  input  asa_pkg::shelf_wr_t             shelf_wr,
  input  asa_pkg::token_t                tok_in,
  output asa_pkg::token_t                tok_out
);
  import asa_pkg::*;

  logic [DIM_W-1:0]   top_r;
  logic [DIM_W-1:0]   height_r;
  logic [DIM_W-1:0]   used_r;
  logic [DIM_W-1:0]   used_nxt;
  token_t             tok_r;
  token_t             tok_nxt;

  logic [H10_W-1:0]   height7;
  logic [DIM_W:0]     width_sum;
  logic               fits_h;
  logic               fits_w;
  logic               hit;
  logic               wr_here;

  always_comb begin
    height7   = (H10_W'(height_r) << 3) - H10_W'(height_r);
    width_sum = {1'b0, tok_in.w} + {1'b0, used_r};
    fits_h    = (tok_in.h10 >= height7) && (tok_in.h <= height_r);
    fits_w    = width_sum <= {1'b0, atlas_width};
    hit       = tok_in.vld && !tok_in.found && active && fits_h && fits_w;
    wr_here   = shelf_wr.en && (shelf_wr.idx == cell_idx);

    tok_nxt = tok_in;
    if (hit) begin
      tok_nxt.found = 1'b1;
      tok_nxt.left  = used_r;
      tok_nxt.top   = top_r;
    end

    used_nxt = used_r;
    if (wr_here) begin
      used_nxt = shelf_wr.used;
    end else if (hit) begin
      used_nxt = width_sum[DIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
    used_r <= used_nxt;
    if (wr_here) begin
      top_r    <= shelf_wr.top;
      height_r <= shelf_wr.height;
    end
  end

  assign tok_out = tok_r;

endmodule

### design/asa_ctrl.sv
module asa_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [asa_pkg::DIM_W-1:0]       in_req_width,
  input  logic [asa_pkg::DIM_W-1:0]       in_req_height,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [asa_pkg::DIM_W-1:0]       cfg_data,
  output asa_pkg::token_t                 launch,
  input  asa_pkg::token_t                 tail,
  output asa_pkg::shelf_wr_t              shelf_wr,
  output logic [asa_pkg::SHELF_CNT_W-1:0] shelf_count,
  output logic [asa_pkg::DIM_W-1:0]       atlas_width,
  output logic                            out_valid,
  output logic [asa_pkg::DIM_W-1:0]       out_rect_left,
  output logic [asa_pkg::DIM_W-1:0]       out_rect_top,
  output logic [asa_pkg::DIM_W-1:0]       out_rect_width,
  output logic [asa_pkg::DIM_W-1:0]       out_rect_height,
  output logic [asa_pkg::DIM_W-1:0]       out_atlas_width_now,
  output logic [asa_pkg::DIM_W-1:0]       out_atlas_height_now,
  output logic                            out_place_failed
);
  import asa_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_GROW} state_t;

  localparam int PROD_W = DIM_W + RECIP_W;

  state_t             state_r,  state_nxt;
  logic [DIM_W-1:0]   w_r,      w_nxt;
  logic [DIM_W-1:0]   h_r,      h_nxt;
  logic [DIM_W:0]     rh_r,     rh_nxt;
  logic [SHELF_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIM_W-1:0]   nfr_r,    nfr_nxt;
  logic [DIM_W-1:0]   aw_r,     aw_nxt;
  logic [DIM_W-1:0]   ah_r,     ah_nxt;
  logic [DIM_W-1:0]   max_r,    max_nxt;
  logic               ov_r,     ov_nxt;
  logic [DIM_W-1:0]   left_r,   left_nxt;
  logic [DIM_W-1:0]   top_r,    top_nxt;
  logic [DIM_W-1:0]   rw_r,     rw_nxt;
  logic [DIM_W-1:0]   rhgt_r,   rhgt_nxt;
  logic [DIM_W-1:0]   awn_r,    awn_nxt;
  logic [DIM_W-1:0]   ahn_r,    ahn_nxt;
  logic               fail_r,   fail_nxt;

  logic               accept;
  logic [PROD_W-1:0]  h_prod;
  logic [PROD_W-1:0]  h_prod_sh;
  logic [DIM_W+1:0]   row_sum;
  logic               need_grow;
  logic               can_grow;
  logic               table_full;

  always_comb begin
    accept    = start && (state_r == ST_IDLE);
    h_prod    = PROD_W'(in_req_height) * PROD_W'(RECIP_10);
    h_prod_sh = h_prod >> RECIP_SHIFT;
    row_sum   = {2'b0, nfr_r} + {1'b0, rh_r};
    need_grow = (row_sum >= {2'b0, ah_r}) || (w_r >= aw_r);
    can_grow  = ({aw_r, 1'b0} <= {1'b0, max_r}) && ({ah_r, 1'b0} <= {1'b0, max_r});
    table_full = cnt_r == SHELF_CNT_W'(MAX_SHELVES);

    launch       = '0;
    launch.vld   = accept;
    launch.w     = in_req_width;
    launch.h     = in_req_height;
    launch.h10   = (H10_W'(in_req_height) << 3) + (H10_W'(in_req_height) << 1);

    shelf_wr        = '0;
    shelf_wr.idx    = cnt_r[SHELF_IDX_W-1:0];
    shelf_wr.top    = nfr_r;
    shelf_wr.height = rh_r[DIM_W-1:0];
    shelf_wr.used   = w_r;

    state_nxt = state_r;
    w_nxt     = w_r;
    h_nxt     = h_r;
    rh_nxt    = rh_r;
    cnt_nxt   = cnt_r;
    nfr_nxt   = nfr_r;
    aw_nxt    = aw_r;
    ah_nxt    = ah_r;
    max_nxt   = max_r;
    ov_nxt    = 1'b0;
    left_nxt  = left_r;
    top_nxt   = top_r;
    rw_nxt    = rw_r;
    rhgt_nxt  = rhgt_r;
    awn_nxt   = aw_r;
    ahn_nxt   = ah_r;
    fail_nxt  = fail_r;

    if (cfg_valid) begin
      max_nxt = cfg_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          w_nxt     = in_req_width;
          h_nxt     = in_req_height;
          rh_nxt    = {1'b0, in_req_height} + (DIM_W+1)'(h_prod_sh[DIM_W-1:0]);
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tail.vld) begin
          if (tail.found) begin
            ov_nxt    = 1'b1;
            left_nxt  = tail.left;
            top_nxt   = tail.top;
            rw_nxt    = w_r;
            rhgt_nxt  = h_r;
            fail_nxt  = 1'b0;
            state_nxt = ST_IDLE;
          end else if (table_full) begin
            ov_nxt    = 1'b1;
            left_nxt  = '0;
            top_nxt   = '0;
            rw_nxt    = DIM_W'(FAIL_SIZE);
            rhgt_nxt  = DIM_W'(FAIL_SIZE);
            fail_nxt  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_GROW;
          end
        end
      end
      ST_GROW: begin
        if (need_grow) begin
          if (can_grow) begin
            aw_nxt = {aw_r[DIM_W-2:0], 1'b0};
            ah_nxt = {ah_r[DIM_W-2:0], 1'b0};
          end else begin
            ov_nxt    = 1'b1;
            left_nxt  = '0;
            top_nxt   = '0;
            rw_nxt    = DIM_W'(FAIL_SIZE);
            rhgt_nxt  = DIM_W'(FAIL_SIZE);
            fail_nxt  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          // open the shelf and place at its left end
          shelf_wr.en = 1'b1;
          cnt_nxt     = cnt_r + SHELF_CNT_W'(1);
          nfr_nxt     = row_sum[DIM_W-1:0];
          ov_nxt      = 1'b1;
          left_nxt    = '0;
          top_nxt     = nfr_r;
          rw_nxt      = w_r;
          rhgt_nxt    = h_r;
          fail_nxt    = 1'b0;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      nfr_r   <= DIM_W'(FIRST_FREE_ROW);
      aw_r    <= DIM_W'(INITIAL_ATLAS_SIZE);
      ah_r    <= DIM_W'(INITIAL_ATLAS_SIZE);
      max_r   <= DIM_W'(MAX_ATLAS_RESET);
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      nfr_r   <= nfr_nxt;
      aw_r    <= aw_nxt;
      ah_r    <= ah_nxt;
      max_r   <= max_nxt;
      ov_r    <= ov_nxt;
    end
    w_r    <= w_nxt;
    h_r    <= h_nxt;
    rh_r   <= rh_nxt;
    left_r <= left_nxt;
    top_r  <= top_nxt;
    rw_r   <= rw_nxt;
    rhgt_r <= rhgt_nxt;
    awn_r  <= awn_nxt;
    ahn_r  <= ahn_nxt;
    fail_r <= fail_nxt;
  end

  assign busy                 = state_r != ST_IDLE;
  assign cfg_ready            = 1'b1;
  assign shelf_count          = cnt_r;
  assign atlas_width          = aw_r;
  assign out_valid            = ov_r;
  assign out_rect_left        = left_r;
  assign out_rect_top         = top_r;
  assign out_rect_width       = rw_r;
  assign out_rect_height      = rhgt_r;
  assign out_atlas_width_now  = awn_r;
  assign out_atlas_height_now = ahn_r;
  assign out_place_failed     = fail_r;

endmodule

### design/atlas_shelf_allocator.sv
// Shelf packer for a growing square atlas. A request is taken when start is
// high and busy is low; it then walks a chain of MAX_SHELVES shelf cells, one
// cell per cycle, and the first fitting shelf claims it. Its result is strobed
// on out_valid for a single cycle once the token leaves the chain when a shelf
// fits or the table is full, or after the atlas has doubled as needed and a
// new shelf is opened or the growth fails. The receiver cannot stall: capture
// the result in the strobe cycle. busy drops in that same cycle, so the next
// request may be given then. cfg_ready is always high; write max_atlas_size
// only while busy is low.
module atlas_shelf_allocator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [asa_pkg::DIM_W-1:0] in_req_width,
  input  logic [asa_pkg::DIM_W-1:0] in_req_height,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [asa_pkg::DIM_W-1:0] cfg_data,
  output logic                      out_valid,
  output logic [asa_pkg::DIM_W-1:0] out_rect_left,
  output logic [asa_pkg::DIM_W-1:0] out_rect_top,
  output logic [asa_pkg::DIM_W-1:0] out_rect_width,
  output logic [asa_pkg::DIM_W-1:0] out_rect_height,
  output logic [asa_pkg::DIM_W-1:0] out_atlas_width_now,
  output logic [asa_pkg::DIM_W-1:0] out_atlas_height_now,
  output logic                      out_place_failed
);
  import asa_pkg::*;

  token_t                 tok [0:MAX_SHELVES];
  shelf_wr_t              shelf_wr;
  logic [SHELF_CNT_W-1:0] shelf_count;
  logic [DIM_W-1:0]       atlas_width;
  logic [MAX_SHELVES-1:0] active;

  asa_ctrl u_ctrl (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_req_width         (in_req_width),
    .in_req_height        (in_req_height),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_data             (cfg_data),
    .launch               (tok[0]),
    .tail                 (tok[MAX_SHELVES]),
    .shelf_wr             (shelf_wr),
    .shelf_count          (shelf_count),
    .atlas_width          (atlas_width),
    .out_valid            (out_valid),
    .out_rect_left        (out_rect_left),
    .out_rect_top         (out_rect_top),
    .out_rect_width       (out_rect_width),
    .out_rect_height      (out_rect_height),
    .out_atlas_width_now  (out_atlas_width_now),
    .out_atlas_height_now (out_atlas_height_now),
    .out_place_failed     (out_place_failed)
  );

  for (genvar i = 0; i < MAX_SHELVES; i++) begin : g_cell
    // only shelves already opened take part in the scan
    assign active[i] = SHELF_CNT_W'(i) < shelf_count;

    asa_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cell_idx    (SHELF_IDX_W'(i)),
      .active      (active[i]),
      .atlas_width (atlas_width),
      .shelf_wr    (shelf_wr),
      .tok_in      (tok[i]),
      .tok_out     (tok[i+1])
    );
  end

endmodule

### design/asa_checker.sv
`include "atlas_shelf_allocator_defines.svh"

module asa_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input logic [asa_pkg::DIM_W-1:0] out_rect_left,
  input logic [asa_pkg::DIM_W-1:0] out_rect_top,
  input logic [asa_pkg::DIM_W-1:0] out_rect_width,
  input logic [asa_pkg::DIM_W-1:0] out_rect_height,
  input logic [asa_pkg::DIM_W-1:0] out_atlas_width_now,
  input logic [asa_pkg::DIM_W-1:0] out_atlas_height_now,
  input logic                      out_place_failed
);
  import asa_pkg::*;

  // a transfer makes the block busy
  `ASA_ASSERT_NXT(a_start_busy, start && !busy, busy)

  // a result only ends a request that was in flight
  `ASA_ASSERT_IMP(a_result_after_busy, out_valid, $past(busy))

  // failure reports the fixed fallback rectangle
  `ASA_ASSERT_IMP(a_fail_rect, out_valid && out_place_failed, (out_rect_left == '0) && (out_rect_top == '0) && (out_rect_width == DIM_W'(FAIL_SIZE)) && (out_rect_height == DIM_W'(FAIL_SIZE)))

  // the atlas only ever grows in both dimensions together
  `ASA_ASSERT_IMP(a_square_atlas, out_valid, out_atlas_width_now == out_atlas_height_now)

endmodule

bind atlas_shelf_allocator asa_checker u_asa_checker (.*);
